[hw/rtl/rbb_pkg.sv]
// ----------------------------------------------------------------------------
// rbb_pkg
// shared types and constants of the row box blur filter unit
// ----------------------------------------------------------------------------
`default_nettype none

package rbb_pkg;

  // pixel and position widths
  localparam int PIX_W      = 16;
  localparam int POS_W      = 12;
  localparam int WIDTH_W    = POS_W + 1;
  localparam int RAD_W      = 5;
  localparam int NORM_W     = 17;
  localparam int FRAC_W     = 16;
  localparam int SUM_W      = 23;
  localparam int CNT_W      = 6;
  localparam int IDX_W      = 3;

  // limits of the filter
  localparam int MAX_RADIUS = 31;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_OUT    = 32;
  localparam int RING_DEPTH = 2 * MAX_RADIUS + 2;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  // filter modes
  localparam logic MODE_BOX  = 1'b0;
  localparam logic MODE_BLUR = 1'b1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [IDX_W-1:0] REG_RADIUS      = 3'd1;
  localparam logic [IDX_W-1:0] REG_NORM_RECIP  = 3'd2;
  localparam logic [IDX_W-1:0] REG_FRAC_WEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_THRESHOLD   = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROW_WIDTH   = 3'd5;

  typedef struct packed {
    logic               mode;
    logic [RAD_W-1:0]   radius;
    logic [NORM_W-1:0]  norm_recip;
    logic [FRAC_W-1:0]  frac_weight;
    logic [PIX_W-1:0]   threshold;
    logic [WIDTH_W-1:0] row_width;
  } cfg_t;

  // one classified pixel: where it lands and which columns it releases
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] last;
    logic             at_end;
    logic [POS_W-1:0] first;
    logic [CNT_W-1:0] count;
  } job_t;

endpackage

`default_nettype wire

[hw/rtl/rbb_front.sv]
// ----------------------------------------------------------------------------
// rbb_front
// takes pixels, tracks row positions and works out the columns each releases
// ----------------------------------------------------------------------------
`default_nettype none

module rbb_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rbb_pkg::cfg_t       cfg,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [15:0]         in_pixel_in,
  input  wire logic                q_full,
  output logic                     q_push,
  output rbb_pkg::job_t            q_job
);
  import rbb_pkg::*;

  logic [POS_W-1:0]   in_pos_r, in_pos_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [RAD_W-1:0]   la;
  logic [WIDTH_W-1:0] w_eff;
  logic [POS_W:0]     p_ext, op_ext, la_ext, span_end, span_mid, avail;
  logic               at_end;
  logic [CNT_W-1:0]   count;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    la = (cfg.mode == MODE_BOX) ? cfg.radius : RAD_W'(1);
    if (cfg.row_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (cfg.row_width > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg.row_width;
    end
    p_ext    = {1'b0, in_pos_r};
    op_ext   = {1'b0, out_pos_r};
    la_ext   = (POS_W + 1)'(la);
    at_end   = (p_ext + (POS_W + 1)'(1)) >= w_eff;
    span_end = p_ext - op_ext + (POS_W + 1)'(1);
    span_mid = p_ext - op_ext - la_ext + (POS_W + 1)'(1);
    if (at_end) begin
      avail = span_end;
    end else if (op_ext + la_ext <= p_ext) begin
      avail = span_mid;
    end else begin
      avail = '0;
    end
    // at most a burst of results per pixel, the rest of a row end is lost
    count = (avail > (POS_W + 1)'(MAX_OUT)) ? CNT_W'(MAX_OUT) : avail[CNT_W-1:0];

    in_pos_nxt  = at_end ? '0 : in_pos_r + POS_W'(1);
    out_pos_nxt = at_end ? '0 : out_pos_r + POS_W'(count);
  end

  always_comb begin
    q_job.pixel  = in_pixel_in;
    q_job.last   = in_pos_r;
    q_job.at_end = at_end;
    q_job.first  = out_pos_r;
    q_job.count  = count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pos_r  <= '0;
      out_pos_r <= '0;
    end else if (q_push) begin
      in_pos_r  <= in_pos_nxt;
      out_pos_r <= out_pos_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rbb_queue.sv]
// ----------------------------------------------------------------------------
// rbb_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module rbb_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rbb_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output rbb_pkg::job_t      head,
  output logic               empty
);
  import rbb_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  job_t          entries_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   fill_r, fill_nxt;

  assign full  = (fill_r == (AW + 1)'(DEPTH));
  assign empty = (fill_r == '0);
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (AW + 1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rbb_back.sv]
// ----------------------------------------------------------------------------
// rbb_back
// window ring, tap sequencer, shared multiplier and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rbb_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rbb_pkg::cfg_t cfg,
  input  wire logic          shape_wr,
  input  wire logic          q_empty,
  input  wire rbb_pkg::job_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [15:0]        out_pixel_out,
  output logic [11:0]        out_column,
  output logic               out_row_end
);
  import rbb_pkg::*;

  localparam int PROD_W = SUM_W + NORM_W;
  localparam int TAP_W  = RAD_W + 1;
  localparam int IDX_SW = POS_W + 2;
  localparam int T_W    = PIX_W + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_TAP   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_MID   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // column kinds
  localparam logic [1:0] K_RECOMP = 2'd0;
  localparam logic [1:0] K_INCR   = 2'd1;
  localparam logic [1:0] K_BLUR   = 2'd2;
  localparam logic [1:0] K_COPY   = 2'd3;

  // tap roles
  localparam logic [1:0] R_ADD = 2'd0;
  localparam logic [1:0] R_SUB = 2'd1;
  localparam logic [1:0] R_CTR = 2'd2;

  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(32768);

  logic [2:0]          state_r, state_nxt;
  logic [PIX_W-1:0]    ring_mem [RING_DEPTH];
  logic [PIX_W-1:0]    rd_data_r;
  logic [PIX_W-1:0]    left_edge_r;
  logic [POS_W-1:0]    c_r, last_r;
  logic                at_end_r;
  logic [CNT_W-1:0]    rem_r;
  logic [1:0]          kind_r, setup_kind;
  logic [TAP_W-1:0]    tap_r, tap_last_r, setup_tap_last;
  logic                pass2_r;
  logic                rd_en_r, rd_left_r;
  logic [1:0]          rd_role_r, tap_role;
  logic [SUM_W-1:0]    window_sum_r;
  logic [PIX_W-1:0]    centre_r;
  logic                sum_valid_r;
  logic [PROD_W-1:0]   prod_r, mul_p;
  logic [SUM_W-1:0]    mul_a;
  logic [NORM_W-1:0]   mul_b;
  logic [T_W-1:0]      t_r, t_calc;
  logic [PIX_W-1:0]    res_r, fin_val, sat_val;
  logic [PROD_W:0]     rnd_fin;
  logic [PROD_W-1:0]   rnd_mid;
  logic [PROD_W-16:0]  shifted;
  logic signed [IDX_SW-1:0] c_s, last_s, r_s, tap_idx, tap_clamped;
  logic                use_left;
  logic [RING_AW-1:0]  tap_addr;
  logic [PIX_W-1:0]    tap_data;
  logic                out_valid_r;
  logic [PIX_W-1:0]    out_pixel_r;
  logic [POS_W-1:0]    out_column_r;
  logic                out_row_end_r;
  logic                out_free, col_done, last_col;

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_column    = out_column_r;
  assign out_row_end   = out_row_end_r;

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;
  assign col_done = (state_r == S_OUT) && out_free;
  assign last_col = (rem_r == CNT_W'(1));

  // column kind and tap count
  always_comb begin
    if (cfg.mode == MODE_BOX) begin
      setup_kind = sum_valid_r ? K_INCR : K_RECOMP;
    end else if ((c_r == '0) || (at_end_r && (c_r == last_r))) begin
      setup_kind = K_COPY;
    end else begin
      setup_kind = K_BLUR;
    end
    unique case (setup_kind)
      K_RECOMP: setup_tap_last = {cfg.radius, 1'b0};
      K_INCR:   setup_tap_last = TAP_W'(1);
      K_BLUR:   setup_tap_last = TAP_W'(2);
      K_COPY:   setup_tap_last = '0;
    endcase
  end

  // tap position, edge clamp and ring address
  always_comb begin
    c_s    = signed'({2'b00, c_r});
    last_s = signed'({2'b00, last_r});
    r_s    = signed'(IDX_SW'(cfg.radius));
    unique case (kind_r)
      K_RECOMP: begin
        tap_idx  = c_s - r_s + signed'(IDX_SW'(tap_r));
        tap_role = R_ADD;
      end
      K_INCR: begin
        // new right tap in, old left tap out
        tap_idx  = (tap_r == '0) ? c_s + r_s : c_s - r_s - IDX_SW'(1);
        tap_role = (tap_r == '0) ? R_ADD : R_SUB;
      end
      K_BLUR: begin
        if (tap_r == '0) begin
          tap_idx = c_s - IDX_SW'(1);
        end else if (tap_r == TAP_W'(1)) begin
          tap_idx = c_s + IDX_SW'(1);
        end else begin
          tap_idx = c_s;
        end
        tap_role = (tap_r == TAP_W'(2)) ? R_CTR : R_ADD;
      end
      K_COPY: begin
        tap_idx  = c_s;
        tap_role = R_CTR;
      end
    endcase
    tap_clamped = (tap_idx > last_s) ? last_s : tap_idx;
    use_left    = (tap_clamped <= 0);
    tap_addr    = tap_clamped[RING_AW-1:0];
  end

  assign tap_data = rd_left_r ? left_edge_r : rd_data_r;

  // shared multiplier and rounding
  always_comb begin
    mul_a   = pass2_r ? SUM_W'(t_r) : window_sum_r;
    mul_b   = ((kind_r == K_BLUR) && !pass2_r) ? NORM_W'(cfg.frac_weight) : cfg.norm_recip;
    mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
    rnd_mid = prod_r + PROD_W'(32768);
    t_calc  = T_W'(rnd_mid[PROD_W-1:16]) + T_W'(centre_r);
    rnd_fin = (PROD_W + 1)'(prod_r) + ROUND_HALF;
    shifted = rnd_fin[PROD_W:16];
    sat_val = (shifted > (PROD_W - 15)'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : shifted[PIX_W-1:0];
    fin_val = (sat_val < cfg.threshold) ? '0 : sat_val;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop && (q_head.count != '0)) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: state_nxt = S_TAP;
      S_TAP: begin
        if (tap_r == tap_last_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_MUL;
      S_MUL: begin
        if (kind_r == K_COPY) begin
          state_nxt = S_OUT;
        end else if ((kind_r == K_BLUR) && !pass2_r) begin
          state_nxt = S_MID;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MID: state_nxt = S_MUL;
      S_FIN: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = last_col ? S_IDLE : S_SETUP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // window ring
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ring_mem[q_head.last[RING_AW-1:0]] <= q_head.pixel;
    end
    if (state_r == S_TAP) begin
      rd_data_r <= ring_mem[tap_addr];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_en_r     <= 1'b0;
      sum_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      left_edge_r <= '0;
      window_sum_r <= '0;
    end else begin
      state_r <= state_nxt;
      rd_en_r <= (state_r == S_TAP);

      if (q_pop && (q_head.last == '0)) begin
        left_edge_r <= q_head.pixel;
      end

      // running sum
      if ((state_r == S_SETUP) && (setup_kind != K_INCR)) begin
        window_sum_r <= '0;
      end else if (rd_en_r && (rd_role_r == R_ADD)) begin
        window_sum_r <= window_sum_r + SUM_W'(tap_data);
      end else if (rd_en_r && (rd_role_r == R_SUB)) begin
        window_sum_r <= window_sum_r - SUM_W'(tap_data);
      end

      // the running sum only carries over to the next column of the same row
      if (shape_wr) begin
        sum_valid_r <= 1'b0;
      end else if ((state_r == S_MUL) && ((kind_r == K_RECOMP) || (kind_r == K_INCR))) begin
        sum_valid_r <= 1'b1;
      end else if (col_done && last_col && at_end_r) begin
        sum_valid_r <= 1'b0;
      end else if (q_pop && (q_head.count == '0) && q_head.at_end) begin
        sum_valid_r <= 1'b0;
      end

      if (col_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      c_r      <= q_head.first;
      last_r   <= q_head.last;
      at_end_r <= q_head.at_end;
      rem_r    <= q_head.count;
    end else if (col_done) begin
      c_r   <= c_r + POS_W'(1);
      rem_r <= rem_r - CNT_W'(1);
    end

    if (state_r == S_SETUP) begin
      kind_r     <= setup_kind;
      tap_last_r <= setup_tap_last;
      tap_r      <= '0;
      pass2_r    <= 1'b0;
    end else if (state_r == S_TAP) begin
      tap_r <= tap_r + TAP_W'(1);
    end else if (state_r == S_MID) begin
      pass2_r <= 1'b1;
    end

    rd_left_r <= use_left;
    rd_role_r <= tap_role;
    if (rd_en_r && (rd_role_r == R_CTR)) begin
      centre_r <= tap_data;
    end

    if ((state_r == S_MUL) && (kind_r != K_COPY)) begin
      prod_r <= mul_p;
    end
    if (state_r == S_MID) begin
      t_r <= t_calc;
    end
    if ((state_r == S_MUL) && (kind_r == K_COPY)) begin
      res_r <= centre_r;
    end else if (state_r == S_FIN) begin
      res_r <= fin_val;
    end

    if (col_done) begin
      out_pixel_r   <= res_r;
      out_column_r  <= c_r;
      out_row_end_r <= at_end_r && (c_r == last_r);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/row_box_blur_filter_unit.sv]
// ----------------------------------------------------------------------------
// row_box_blur_filter_unit
// row box average and fractional three-tap blur over a pixel stream
// ----------------------------------------------------------------------------
//
//   channel   ports                                         direction
//   -------   --------------------------------------------  ---------
//   in        in_valid, in_stall, in_pixel_in               pixels in
//   out       out_valid, out_stall, out_pixel_out,          results out
//             out_column, out_row_end
//   cfg       cfg_we, cfg_index, cfg_wdata                  register writes
//
// the front takes one pixel a cycle while the four-entry job queue has room
// per result column the tap sequencer reads its taps through the single ring
// read port: the new right and old left taps in box mode with the running sum,
// the whole window when the sum is rebuilt (row start or after a mode or radius
// write), both neighbours and the centre for a blurred column and the centre
// alone for a copied end pixel; each pixel's job is popped and written to the ring
// synchronous active-low reset; the ring needs no clearing pass
// out_stall holds the result register and backs up through the queue to in_stall
//
`default_nettype none

module row_box_blur_filter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // pixel transactions
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_pixel_in,
  // result transactions
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_pixel_out,
  output logic [11:0]      out_column,
  output logic             out_row_end,
  // register writes
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata
);
  import rbb_pkg::*;

  cfg_t cfg_r;
  job_t push_job, head_job;
  logic q_push, q_full, q_pop, q_empty;
  logic shape_wr;

  // a mode or radius write makes the running box sum stale
  assign shape_wr = cfg_we && ((cfg_index == REG_MODE) || (cfg_index == REG_RADIUS));

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_BOX;
      cfg_r.radius      <= RAD_W'(1);
      cfg_r.norm_recip  <= NORM_W'(21845);
      cfg_r.frac_weight <= '0;
      cfg_r.threshold   <= PIX_W'(1);
      cfg_r.row_width   <= WIDTH_W'(MAX_WIDTH);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:        cfg_r.mode        <= cfg_wdata[0];
        REG_RADIUS:      cfg_r.radius      <= cfg_wdata[RAD_W-1:0];
        REG_NORM_RECIP:  cfg_r.norm_recip  <= cfg_wdata[NORM_W-1:0];
        REG_FRAC_WEIGHT: cfg_r.frac_weight <= cfg_wdata[FRAC_W-1:0];
        REG_THRESHOLD:   cfg_r.threshold   <= cfg_wdata[PIX_W-1:0];
        REG_ROW_WIDTH:   cfg_r.row_width   <= cfg_wdata[WIDTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: row position tracking and release of due columns
  rbb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel_in(in_pixel_in),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  // job queue decouples pixel intake from result production
  rbb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .head    (head_job),
    .empty   (q_empty)
  );

  // back: ring write, window taps, normalising and the result register
  rbb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .shape_wr     (shape_wr),
    .q_empty      (q_empty),
    .q_head       (head_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel_out(out_pixel_out),
    .out_column   (out_column),
    .out_row_end  (out_row_end)
  );

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for row_box_blur_filter_unit: a clocked driver feeds
// pixel transactions and register writes from a planned queue, a clocked
// monitor compares every result transaction with a local row filter model
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import rbb_pkg::*;

  localparam int SETTLE_CYCLES = 200;  // idle time before a register write
  localparam int DRAIN_CYCLES  = 300;  // quiet time after the last result
  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam int STALL_PCT     = 11;
  localparam int RANDOM_PIXELS = 290;

  // one planned step: a pixel transaction or a register write
  typedef struct {
    bit                is_reg;
    logic [IDX_W-1:0]  idx;
    logic [NORM_W-1:0] data;
    logic [PIX_W-1:0]  pixel;
  } feed_op_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] column;
    logic             row_end;
  } blur_result_t;

  logic clk;
  logic rst_n;

  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   in_pixel_in = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [PIX_W-1:0]   out_pixel_out;
  logic [POS_W-1:0]   out_column;
  logic               out_row_end;
  logic               cfg_we      = 1'b0;
  logic [IDX_W-1:0]   cfg_index   = '0;
  logic [NORM_W-1:0]  cfg_wdata   = '0;

  row_box_blur_filter_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_column    (out_column),
    .out_row_end   (out_row_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // row filter model: settings, window ring and row positions
  // --------------------------------------------------------------------------
  logic               cur_mode   = MODE_BOX;
  logic [RAD_W-1:0]   cur_radius = 5'd1;
  logic [NORM_W-1:0]  cur_norm   = 17'd21845;
  logic [FRAC_W-1:0]  cur_frac   = '0;
  logic [PIX_W-1:0]   cur_thresh = 16'd1;
  logic [WIDTH_W-1:0] cur_width  = 13'd4096;

  logic [PIX_W-1:0]   line_ring [RING_DEPTH];
  logic [PIX_W-1:0]   first_pix = '0;
  int                 in_col    = 0;   // position of the next pixel in its row
  int                 out_col   = 0;   // next column still owed a result

  blur_result_t       want_q [$];      // results owed by the block, oldest first
  feed_op_t           feed_q [$];

  int errors       = 0;
  int pix_taken    = 0;
  int results_seen = 0;
  bit feed_done    = 0;
  int hold_at      = 1 << 30;
  int burst_lo     = 1 << 30;
  int burst_hi     = 1 << 30;

  // planning state, used only while the feed queue is built
  int               plan_col    = 0;
  int               plan_width  = MAX_WIDTH;
  int               plan_pixels = 0;
  logic [PIX_W-1:0] last_pick   = '0;

  function automatic void write_setting(logic [IDX_W-1:0] idx, logic [NORM_W-1:0] val);
    case (idx)
      REG_MODE:        cur_mode   = val[0];
      REG_RADIUS:      cur_radius = val[RAD_W-1:0];
      REG_NORM_RECIP:  cur_norm   = val;
      REG_FRAC_WEIGHT: cur_frac   = val[FRAC_W-1:0];
      REG_THRESHOLD:   cur_thresh = val[PIX_W-1:0];
      REG_ROW_WIDTH:   cur_width  = val[WIDTH_W-1:0];
      default: ;
    endcase
  endfunction

  // pixel at row position i, clamped to the row start and to the newest pixel
  function automatic logic [63:0] tap_pixel(int i, int last);
    int j;
    j = (i > last) ? last : i;
    if (j <= 0) return 64'(first_pix);
    return 64'(line_ring[j % RING_DEPTH]);
  endfunction

  // scale by the reciprocal, round, saturate and apply the threshold
  function automatic logic [PIX_W-1:0] round_scale(logic [63:0] acc);
    logic [63:0] v;
    v = (acc * 64'(cur_norm) + 64'h8000) >> 16;
    if (v > 64'hFFFF) v = 64'hFFFF;
    if (v < 64'(cur_thresh)) v = '0;
    return v[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] filter_column(int c, int last, bit at_end);
    logic [63:0] acc;
    logic [63:0] lft;
    logic [63:0] rgt;
    int          k;
    if (cur_mode == MODE_BOX) begin
      acc = '0;
      for (k = -int'(cur_radius); k <= int'(cur_radius); k++)
        acc += tap_pixel(c + k, last);
      return round_scale(acc);
    end
    // end pixels of a blurred row pass straight through, no threshold
    if (c == 0 || (at_end && c == last))
      return tap_pixel(c, last);
    lft = tap_pixel(c - 1, last);
    rgt = tap_pixel(c + 1, last);
    acc = (((lft + rgt) * 64'(cur_frac) + 64'h8000) >> 16) + tap_pixel(c, last);
    return round_scale(acc);
  endfunction

  // one accepted pixel: store it and queue every column it releases
  function automatic void filter_pixel(logic [PIX_W-1:0] px);
    int           w;
    int           p;
    int           ahead;
    int           n;
    bit           at_end;
    blur_result_t res;
    w = int'(cur_width);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    p = in_col;
    ahead = (cur_mode == MODE_BOX) ? int'(cur_radius) : 1;
    line_ring[p % RING_DEPTH] = px;
    if (p == 0) first_pix = px;
    at_end = (p + 1 >= w);
    n = 0;
    while (n < MAX_OUT && out_col <= p && (at_end || out_col + ahead <= p)) begin
      res.pixel   = filter_column(out_col, p, at_end);
      res.column  = out_col[POS_W-1:0];
      res.row_end = at_end && (out_col == p);
      want_q.push_back(res);
      out_col++;
      n++;
    end
    if (at_end) begin
      in_col  = 0;
      out_col = 0;
    end else begin
      in_col = p + 1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // planning helpers
  // --------------------------------------------------------------------------
  task automatic plan_pixel(logic [PIX_W-1:0] px);
    feed_op_t op;
    op.is_reg = 1'b0;
    op.idx    = '0;
    op.data   = '0;
    op.pixel  = px;
    feed_q.push_back(op);
    plan_pixels++;
    if (plan_col + 1 >= plan_width) plan_col = 0;
    else plan_col++;
  endtask

  task automatic plan_reg(logic [IDX_W-1:0] idx, int val);
    feed_op_t op;
    int       w;
    op.is_reg = 1'b1;
    op.idx    = idx;
    op.data   = val[NORM_W-1:0];
    op.pixel  = '0;
    feed_q.push_back(op);
    if (idx == REG_ROW_WIDTH) begin
      w = val & 32'h1FFF;
      plan_width = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    end
  endtask

  // mix of black, white, smooth runs and full-range noise
  function automatic logic [PIX_W-1:0] pick_pixel();
    int               sel;
    logic [PIX_W-1:0] v;
    sel = $urandom_range(99);
    if (sel < 8) v = '0;
    else if (sel < 16) v = '1;
    else if (sel < 40) v = last_pick + PIX_W'($urandom_range(512)) - 16'd256;
    else v = PIX_W'($urandom_range(65535));
    last_pick = v;
    return v;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // clock, reset and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus plan
  // --------------------------------------------------------------------------
  initial begin
    int     k;
    int     n;
    int     w;
    int     sel;
    int     rnd_count;
    int     mode_pick;
    int     radius_pick;
    int     frac_pick;
    int     thr_pick;
    longint norm_pick;

    // reset settings: box of radius 1 over a 4096-wide row, row left open
    plan_pixel(16'h0000);
    plan_pixel(16'hFFFF);
    plan_pixel(16'hFFFF);
    plan_pixel(16'h0000);
    plan_pixel(16'd12345);
    // width cut below the current position, next pixel closes the row
    plan_reg(REG_ROW_WIDTH, 1);
    plan_pixel(16'd54321);
    // single-pixel row in box mode
    plan_pixel(16'hFFFF);
    // single-pixel row in blur mode is a plain copy
    plan_reg(REG_MODE, MODE_BLUR);
    plan_reg(REG_FRAC_WEIGHT, 65535);
    plan_reg(REG_NORM_RECIP, 65536);
    plan_reg(REG_THRESHOLD, 0);
    plan_pixel(16'd40000);
    // full-weight neighbours drive the blur into saturation
    plan_reg(REG_ROW_WIDTH, 5);
    plan_pixel(16'h0000);
    plan_pixel(16'hFFFF);
    plan_pixel(16'hFFFF);
    plan_pixel(16'hFFFF);
    plan_pixel(16'h0001);
    // copied end pixels escape the top threshold
    plan_reg(REG_ROW_WIDTH, 2);
    plan_reg(REG_THRESHOLD, 65535);
    plan_pixel(16'd100);
    plan_pixel(16'd200);
    // widest box on a short row: clamping at both edges, oversized reciprocal
    plan_reg(REG_MODE, MODE_BOX);
    plan_reg(REG_RADIUS, 31);
    plan_reg(REG_NORM_RECIP, 131071);
    plan_reg(REG_THRESHOLD, 0);
    plan_reg(REG_ROW_WIDTH, 3);
    plan_pixel(16'hFFFF);
    plan_pixel(16'h0000);
    plan_pixel(16'hFFFF);
    // zero radius is a pass-through, top threshold kills all but full scale
    plan_reg(REG_RADIUS, 0);
    plan_reg(REG_NORM_RECIP, 65536);
    plan_reg(REG_THRESHOLD, 65535);
    plan_reg(REG_ROW_WIDTH, 4);
    plan_pixel(16'hFFFF);
    plan_pixel(16'hFFFE);
    plan_pixel(16'h0000);
    plan_pixel(16'hFFFF);
    // oversized width acts as the maximum, zero width then closes the row
    plan_reg(REG_ROW_WIDTH, 8191);
    plan_reg(REG_NORM_RECIP, 0);
    plan_reg(REG_THRESHOLD, 0);
    plan_pixel(16'd7);
    plan_pixel(16'd9);
    plan_pixel(16'd11);
    plan_reg(REG_ROW_WIDTH, 0);
    plan_pixel(16'd13);

    // back-pressure phase: sender never idles while the receiver holds off
    plan_reg(REG_RADIUS, 2);
    plan_reg(REG_NORM_RECIP, 13107);
    plan_reg(REG_THRESHOLD, 1);
    plan_reg(REG_ROW_WIDTH, 8);
    hold_at  = plan_pixels;
    burst_lo = plan_pixels;
    for (k = 0; k < 64; k++) plan_pixel(pick_pixel());
    burst_hi = plan_pixels;

    // random phases: new settings, then mostly whole rows of random content
    rnd_count = 0;
    while (rnd_count < RANDOM_PIXELS) begin
      mode_pick = $urandom_range(1);
      sel = $urandom_range(99);
      radius_pick = (sel < 15) ? 31 : ((sel < 60) ? $urandom_range(4) : $urandom_range(31));
      frac_pick = $urandom_range(65535);
      if ($urandom_range(9) == 0) norm_pick = $urandom_range(131071);
      else if (mode_pick == MODE_BOX) norm_pick = (65536 + radius_pick) / (2 * radius_pick + 1);
      else norm_pick = (longint'(65536) * 65536) / (65536 + 2 * frac_pick);
      thr_pick = ($urandom_range(99) < 15) ? $urandom_range(65535) : $urandom_range(255);
      sel = $urandom_range(99);
      if (sel < 6) w = $urandom_range(1);
      else if (sel < 12) w = $urandom_range(1) ? MAX_WIDTH : 8191;
      else if (sel < 30) w = $urandom_range(80, 25);
      else w = $urandom_range(24, 2);

      if ($urandom_range(4) != 0) plan_reg(REG_MODE, mode_pick);
      if ($urandom_range(4) != 0) plan_reg(REG_RADIUS, radius_pick);
      if ($urandom_range(4) != 0) plan_reg(REG_NORM_RECIP, int'(norm_pick));
      if ($urandom_range(4) != 0) plan_reg(REG_FRAC_WEIGHT, frac_pick);
      if ($urandom_range(4) != 0) plan_reg(REG_THRESHOLD, thr_pick);
      if ($urandom_range(4) != 0) plan_reg(REG_ROW_WIDTH, w);

      w = plan_width;
      if (w >= 2048) begin
        // very long row: only a stretch of it, a later width write cuts it
        n = $urandom_range(60, 20);
      end else begin
        n = (w > plan_col) ? w - plan_col : 1;
        if (w <= 40) n += w * $urandom_range(3);
        // sometimes leave the row open so the next settings land mid-row
        if (w > 1 && $urandom_range(4) == 0) n += $urandom_range(w - 1, 1);
      end
      // keep the total close to the planned pixel count
      if (n > RANDOM_PIXELS - rnd_count) n = RANDOM_PIXELS - rnd_count;
      for (k = 0; k < n; k++) plan_pixel(pick_pixel());
      rnd_count += n;
    end
  end

  // --------------------------------------------------------------------------
  // driver: pixel transactions and register writes at the rising edge
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    logic              nxt_valid;
    logic [PIX_W-1:0]  nxt_pixel;
    logic              nxt_we;
    logic [IDX_W-1:0]  nxt_idx;
    logic [NORM_W-1:0] nxt_data;
    feed_op_t          op;
    nxt_valid = in_valid;
    nxt_pixel = in_pixel_in;
    nxt_we    = 1'b0;
    nxt_idx   = cfg_index;
    nxt_data  = cfg_wdata;
    if (!rst_n) begin
      nxt_valid    = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (in_valid && !in_stall) begin
        filter_pixel(in_pixel_in);
        pix_taken++;
        quiet_cycles = 0;
        nxt_valid    = 1'b0;
      end
      if (!nxt_valid) begin
        if (feed_q.size() == 0) begin
          feed_done = 1'b1;
        end else if (!feed_q[0].is_reg) begin
          // random gaps, none inside the back-pressure phase
          if ((pix_taken >= burst_lo && pix_taken < burst_hi) ||
              $urandom_range(99) >= STALL_PCT) begin
            op        = feed_q.pop_front();
            nxt_valid = 1'b1;
            nxt_pixel = op.pixel;
          end
        end else begin
          // settings change only once the block has gone quiet
          if (want_q.size() == 0) quiet_cycles++;
          else quiet_cycles = 0;
          if (quiet_cycles >= SETTLE_CYCLES) begin
            op       = feed_q.pop_front();
            nxt_we   = 1'b1;
            nxt_idx  = op.idx;
            nxt_data = op.data;
            write_setting(op.idx, op.data);
          end
        end
      end
    end
    in_valid    <= nxt_valid;
    in_pixel_in <= nxt_pixel;
    cfg_we      <= nxt_we;
    cfg_index   <= nxt_idx;
    cfg_wdata   <= nxt_data;
  end

  // --------------------------------------------------------------------------
  // monitor: result checks and receiver stalls
  // --------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 0;

  always @(posedge clk) begin
    logic         nxt_stall;
    blur_result_t want;
    nxt_stall = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $error("result with nothing owed: column %0d pixel %0d", out_column, out_pixel_out);
          errors++;
        end else begin
          want = want_q.pop_front();
          check_field("pixel_out", want.pixel, out_pixel_out);
          check_field("column", want.column, out_column);
          check_field("row_end", want.row_end, out_row_end);
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        nxt_stall = 1'b1;
        hold_left--;
      end else if (!hold_done && pix_taken >= hold_at) begin
        // long hold-off so the job queue fills and the input backs up
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        nxt_stall = 1'b1;
      end else if (results_seen >= 150 && results_seen < 260) begin
        nxt_stall = 1'b0;  // stretch with the receiver always ready
      end else begin
        nxt_stall = ($urandom_range(99) < STALL_PCT);
      end
    end
    out_stall <= nxt_stall;
  end

  // --------------------------------------------------------------------------
  // end of run
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_n);
    while (!(feed_done && want_q.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
